// File: src/jfop_pkg.sv
// Shared types, character codes and token/error codes for the flat JSON object parser.
package jfop_pkg;

	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);
	localparam int QCW = $clog2(QDEPTH + 1);

	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_POINT  = 8'h2E;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_LO_B   = 8'h62;
	localparam logic [7:0] CH_LO_E   = 8'h65;
	localparam logic [7:0] CH_UP_E   = 8'h45;
	localparam logic [7:0] CH_LO_F   = 8'h66;
	localparam logic [7:0] CH_LO_N   = 8'h6E;
	localparam logic [7:0] CH_LO_R   = 8'h72;
	localparam logic [7:0] CH_LO_T   = 8'h74;
	localparam logic [7:0] CH_LO_U   = 8'h75;
	localparam logic [7:0] CH_BS     = 8'h08;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	localparam logic [2:0] HEX_SKIP   = 3'd4;
	localparam logic [2:0] TRUE_SKIP  = 3'd3;
	localparam logic [2:0] FALSE_SKIP = 3'd4;

	typedef enum logic [3:0] {
		TK_NONE      = 4'd0,
		TK_OPEN      = 4'd1,
		TK_KEY_BYTE  = 4'd2,
		TK_KEY_END   = 4'd3,
		TK_STR_BYTE  = 4'd4,
		TK_STR_END   = 4'd5,
		TK_NUM_BYTE  = 4'd6,
		TK_TRUE      = 4'd7,
		TK_FALSE     = 4'd8,
		TK_CLOSE     = 4'd9,
		TK_VAL_START = 4'd10
	} tok_t;

	typedef enum logic [3:0] {
		ER_NONE     = 4'd0,
		ER_OBJECT   = 4'd1,
		ER_VALUE    = 4'd2,
		ER_STRSTART = 4'd3,
		ER_ESCAPE   = 4'd4,
		ER_UNTERM   = 4'd5,
		ER_NUMBER   = 4'd6,
		ER_SEP      = 4'd7,
		ER_EARLY    = 4'd8,
		ER_TRAILING = 4'd9
	} err_t;

	typedef enum logic [3:0] {
		PH_OPEN, PH_MEMBER, PH_KEYSTART, PH_KEY, PH_KEY_ESC, PH_KEY_HEX,
		PH_STR, PH_STR_ESC, PH_STR_HEX, PH_COLON, PH_VALUE, PH_NUMBER,
		PH_BOOL, PH_DONE
	} phase_t;

	typedef enum logic [2:0] {
		NP_EXP_DIG, NP_SIGN, NP_ZERO, NP_INT, NP_POINT, NP_FRAC, NP_E, NP_EXP_SIGN
	} nphase_t;

	typedef enum logic [1:0] {
		NR_TAKE, NR_END, NR_BAD
	} nres_t;

	typedef struct packed {
		logic ws;
		logic dig;
		logic expo;
		logic sign;
	} cls_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       last_byte;
		cls_t       cls;
	} item_t;

endpackage

// File: src/jfop_front.sv
// Front end: takes input transfers, classifies each byte and pushes it into the queue.
module jfop_front import jfop_pkg::*; (
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] ch,
	input  logic       last_byte,
	input  logic       q_full,
	output logic       q_push,
	output item_t      q_item
);

	cls_t cls;

	always_comb begin
		cls.ws   = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
		cls.dig  = (ch >= CH_ZERO) && (ch <= 8'h39);
		cls.expo = (ch == CH_LO_E) || (ch == CH_UP_E);
		cls.sign = (ch == CH_PLUS) || (ch == CH_MINUS);
	end

	assign in_ready         = !q_full;
	assign q_push           = in_valid && !q_full;
	assign q_item.ch        = ch;
	assign q_item.last_byte = last_byte;
	assign q_item.cls       = cls;

endmodule

// File: src/jfop_queue.sv
// Short queue of classified bytes between front and back.
module jfop_queue import jfop_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	input  logic  pop,
	output item_t head_item,
	output logic  full,
	output logic  not_empty
);

	item_t          mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QCW-1:0] cnt_q;

	assign full      = (cnt_q == QCW'(QDEPTH));
	assign not_empty = (cnt_q != '0);
	assign head_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: src/jfop_back.sv
// Back end: parser state machine and output register.
module jfop_back import jfop_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_not_empty,
	input  item_t      q_item,
	output logic       q_pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [3:0] token_kind,
	output logic [7:0] data_byte,
	output logic       number_end,
	output logic [3:0] error_code,
	output logic       doc_done
);

	phase_t     phase_q;
	logic       pair_q;
	logic [2:0] skip_q;
	nphase_t    nph_q;
	err_t       held_q;

	logic       out_valid_q;
	tok_t       kind_q;
	logic [7:0] data_q;
	logic       nend_q;
	err_t       err_q;
	logic       done_q;

	// per-byte step results
	nres_t      nres;
	nphase_t    nph_num;
	phase_t     p_phase;
	logic       p_pair;
	logic [2:0] p_skip;
	nphase_t    p_nph;
	tok_t       p_kind;
	logic [7:0] p_data;
	logic       p_nend;
	err_t       p_err;

	phase_t     phase_d;
	logic       pair_d;
	logic [2:0] skip_d;
	nphase_t    nph_d;
	err_t       held_d;

	tok_t       o_kind;
	logic [7:0] o_data;
	logic       o_nend;
	err_t       o_err;
	logic       o_done;

	logic [7:0] c;
	cls_t       cl;
	logic [2:0] skip_dec;

	assign c        = q_item.ch;
	assign cl       = q_item.cls;
	assign q_pop    = q_not_empty && (!out_valid_q || out_ready);
	assign skip_dec = (skip_q != '0) ? skip_q - 3'd1 : skip_q;

	// number sub-state step
	always_comb begin
		nres    = NR_TAKE;
		nph_num = nph_q;
		unique case (nph_q)
			NP_SIGN: begin
				if (c == CH_ZERO) nph_num = NP_ZERO;
				else if (cl.dig) nph_num = NP_INT;
				else nres = NR_BAD;
			end
			NP_ZERO: begin
				if (c == CH_POINT) nph_num = NP_POINT;
				else if (cl.expo) nph_num = NP_E;
				else nres = NR_END;
			end
			NP_INT: begin
				if (cl.dig) nph_num = NP_INT;
				else if (c == CH_POINT) nph_num = NP_POINT;
				else if (cl.expo) nph_num = NP_E;
				else nres = NR_END;
			end
			NP_POINT: begin
				if (cl.dig) nph_num = NP_FRAC;
				else nres = NR_BAD;
			end
			NP_FRAC: begin
				if (cl.dig) nph_num = NP_FRAC;
				else if (cl.expo) nph_num = NP_E;
				else nres = NR_END;
			end
			NP_E: begin
				if (cl.sign) nph_num = NP_EXP_SIGN;
				else if (cl.dig) nph_num = NP_EXP_DIG;
				else nres = NR_BAD;
			end
			NP_EXP_SIGN: begin
				if (cl.dig) nph_num = NP_EXP_DIG;
				else nres = NR_BAD;
			end
			default: begin
				if (!cl.dig) nres = NR_END;
			end
		endcase
	end

	// one parser step on the head byte, before error hold and end-of-document handling
	always_comb begin
		phase_t run_ph;
		logic   pair_e;
		logic   key;
		p_phase = phase_q;
		p_pair  = pair_q;
		p_skip  = skip_q;
		p_nph   = nph_q;
		p_kind  = TK_NONE;
		p_data  = '0;
		p_nend  = 1'b0;
		p_err   = ER_NONE;
		run_ph  = phase_q;
		pair_e  = pair_q;
		key     = (phase_q == PH_KEY) || (phase_q == PH_KEY_ESC) || (phase_q == PH_KEY_HEX);
		if (phase_q == PH_NUMBER && nres != NR_END) begin
			if (nres == NR_TAKE) begin
				p_kind = TK_NUM_BYTE;
				p_data = c;
				p_nph  = nph_num;
			end else begin
				p_err = ER_NUMBER;
			end
		end else begin
			if (phase_q == PH_NUMBER) begin
				// the byte closes the number and is then parsed as a member separator
				p_nend  = 1'b1;
				run_ph  = PH_MEMBER;
				pair_e  = 1'b1;
				p_phase = PH_MEMBER;
				p_pair  = 1'b1;
			end
			unique case (run_ph)
				PH_OPEN: begin
					if (!cl.ws) begin
						if (c != CH_LBRACE) p_err = ER_OBJECT;
						else begin
							p_kind  = TK_OPEN;
							p_phase = PH_MEMBER;
						end
					end
				end
				PH_MEMBER: begin
					if (!cl.ws) begin
						if (c == CH_RBRACE) begin
							p_kind  = TK_CLOSE;
							p_phase = PH_DONE;
						end else if (pair_e) begin
							if (c != CH_COMMA) p_err = ER_SEP;
							else p_phase = PH_KEYSTART;
						end else if (c != CH_QUOTE) begin
							p_err = ER_STRSTART;
						end else begin
							p_phase = PH_KEY;
						end
					end
				end
				PH_KEYSTART: begin
					if (!cl.ws) begin
						if (c != CH_QUOTE) p_err = ER_STRSTART;
						else p_phase = PH_KEY;
					end
				end
				PH_KEY, PH_STR: begin
					if (c == CH_QUOTE) begin
						p_kind  = key ? TK_KEY_END : TK_STR_END;
						p_phase = key ? PH_COLON : PH_MEMBER;
						if (!key) p_pair = 1'b1;
					end else if (c == CH_BSLASH) begin
						p_phase = key ? PH_KEY_ESC : PH_STR_ESC;
					end else if (c == CH_NUL) begin
						p_err = ER_UNTERM;
					end else begin
						p_kind = key ? TK_KEY_BYTE : TK_STR_BYTE;
						p_data = c;
					end
				end
				PH_KEY_ESC, PH_STR_ESC: begin
					p_kind  = key ? TK_KEY_BYTE : TK_STR_BYTE;
					p_phase = key ? PH_KEY : PH_STR;
					unique case (c)
						CH_QUOTE:  p_data = CH_QUOTE;
						CH_BSLASH: p_data = CH_BSLASH;
						CH_SLASH:  p_data = CH_SLASH;
						CH_LO_B:   p_data = CH_BS;
						CH_LO_F:   p_data = CH_FF;
						CH_LO_N:   p_data = CH_LF;
						CH_LO_R:   p_data = CH_CR;
						CH_LO_T:   p_data = CH_TAB;
						CH_LO_U: begin
							p_kind  = TK_NONE;
							p_skip  = HEX_SKIP;
							p_phase = key ? PH_KEY_HEX : PH_STR_HEX;
						end
						default: begin
							p_kind  = TK_NONE;
							p_phase = phase_q;
							p_err   = ER_ESCAPE;
						end
					endcase
				end
				PH_KEY_HEX, PH_STR_HEX: begin
					p_skip = skip_dec;
					if (skip_dec == '0) p_phase = key ? PH_KEY : PH_STR;
				end
				PH_COLON: begin
					if (!cl.ws) begin
						if (c != CH_COLON) p_err = ER_SEP;
						else p_phase = PH_VALUE;
					end
				end
				PH_VALUE: begin
					if (!cl.ws) begin
						if (c == CH_QUOTE) begin
							p_kind  = TK_VAL_START;
							p_phase = PH_STR;
						end else if (c == CH_MINUS || cl.dig) begin
							p_nph   = (c == CH_MINUS) ? NP_SIGN :
								(c == CH_ZERO) ? NP_ZERO : NP_INT;
							p_kind  = TK_NUM_BYTE;
							p_data  = c;
							p_phase = PH_NUMBER;
						end else if (c == CH_POINT || cl.expo) begin
							p_err = ER_NUMBER;
						end else if (c == CH_LO_T) begin
							p_kind  = TK_TRUE;
							p_skip  = TRUE_SKIP;
							p_phase = PH_BOOL;
						end else if (c == CH_LO_F) begin
							p_kind  = TK_FALSE;
							p_skip  = FALSE_SKIP;
							p_phase = PH_BOOL;
						end else begin
							p_err = ER_VALUE;
						end
					end
				end
				PH_BOOL: begin
					p_skip = skip_dec;
					if (skip_dec == '0) begin
						p_phase = PH_MEMBER;
						p_pair  = 1'b1;
					end
				end
				PH_DONE: begin
					if (!cl.ws) p_err = ER_TRAILING;
				end
				default: p_err = ER_OBJECT;
			endcase
		end
	end

	// next state
	always_comb begin
		phase_d = phase_q;
		pair_d  = pair_q;
		skip_d  = skip_q;
		nph_d   = nph_q;
		held_d  = held_q;
		if (q_item.last_byte) begin
			phase_d = PH_OPEN;
			pair_d  = 1'b0;
			skip_d  = '0;
			nph_d   = NP_EXP_DIG;
			held_d  = ER_NONE;
		end else if (held_q == ER_NONE) begin
			phase_d = p_phase;
			pair_d  = p_pair;
			skip_d  = p_skip;
			nph_d   = p_nph;
			held_d  = p_err;
		end
	end

	// step outputs
	always_comb begin
		if (held_q != ER_NONE) begin
			o_kind = TK_NONE;
			o_data = '0;
			o_nend = 1'b0;
			o_err  = held_q;
		end else begin
			o_kind = (p_err != ER_NONE) ? TK_NONE : p_kind;
			o_data = (p_err != ER_NONE) ? 8'h00 : p_data;
			o_nend = p_nend;
			o_err  = p_err;
		end
		o_done = 1'b0;
		if (q_item.last_byte) begin
			if (o_err == ER_NONE && p_phase != PH_DONE) o_err = ER_EARLY;
			o_done = (o_err == ER_NONE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_OPEN;
			pair_q      <= 1'b0;
			skip_q      <= '0;
			nph_q       <= NP_EXP_DIG;
			held_q      <= ER_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				phase_q <= phase_d;
				pair_q  <= pair_d;
				skip_q  <= skip_d;
				nph_q   <= nph_d;
				held_q  <= held_d;
			end
			if (q_pop) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			kind_q <= o_kind;
			data_q <= o_data;
			nend_q <= o_nend;
			err_q  <= o_err;
			done_q <= o_done;
		end
	end

	assign out_valid  = out_valid_q;
	assign token_kind = kind_q;
	assign data_byte  = data_q;
	assign number_end = nend_q;
	assign error_code = err_q;
	assign doc_done   = done_q;

endmodule

// File: src/json_flat_object_parser.sv
// Path: a byte transferred in is written into the queue and then popped by the back end into
// the output register. Throughput: one byte per clock while out_ready holds; the parser state
// register closes its loop, and a four-entry queue lets the input run while the output stalls.
// Reset: arst_n clears the queue, the output valid flag and the parser to "expect open brace".
// The parser also returns to that state after each byte marked last_byte.
module json_flat_object_parser import jfop_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] ch,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [3:0] token_kind,
	output logic [7:0] data_byte,
	output logic       number_end,
	output logic [3:0] error_code,
	output logic       doc_done
);

	logic  q_full;
	logic  q_push;
	logic  q_pop;
	logic  q_not_empty;
	item_t push_item;
	item_t head_item;

	jfop_front u_front (
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.ch        (ch),
		.last_byte (last_byte),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_item    (push_item)
	);

	jfop_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.pop       (q_pop),
		.head_item (head_item),
		.full      (q_full),
		.not_empty (q_not_empty)
	);

	jfop_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_item      (head_item),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.token_kind  (token_kind),
		.data_byte   (data_byte),
		.number_end  (number_end),
		.error_code  (error_code),
		.doc_done    (doc_done)
	);

endmodule

// File: src/jfop_checker.sv
// Port-level checks for the parser, attached to the top level by bind.
module jfop_checker import jfop_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [7:0] ch,
	input logic       last_byte,
	input logic       out_valid,
	input logic       out_ready,
	input logic [3:0] token_kind,
	input logic [7:0] data_byte,
	input logic       number_end,
	input logic [3:0] error_code,
	input logic       doc_done
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(token_kind) && $stable(data_byte)
			&& $stable(number_end) && $stable(error_code) && $stable(doc_done))
		else $error("stalled result changed");

	// hold a waiting input transfer
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(ch) && $stable(last_byte))
		else $error("waiting input changed");

	a_done_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && doc_done |-> error_code == ER_NONE)
		else $error("doc_done with an error code");

	// an early end keeps the token of its byte, every other error drops it
	a_err_no_token: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code != ER_NONE && error_code != ER_EARLY
			|-> token_kind == TK_NONE && data_byte == 8'h00)
		else $error("token reported with an error");

	a_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind != TK_KEY_BYTE && token_kind != TK_STR_BYTE
			&& token_kind != TK_NUM_BYTE |-> data_byte == 8'h00)
		else $error("data byte set on a token without data");

endmodule

bind json_flat_object_parser jfop_checker u_jfop_checker (.*);

// File: sim/tb.sv
// Testbench for json_flat_object_parser: random JSON documents checked against a byte-level parser model.
module tb;
	import jfop_pkg::*;

	typedef struct {
		logic [7:0] ch;
		logic       last;
		logic       drain;
	} doc_byte_t;

	typedef struct {
		tok_t       kind;
		logic [7:0] data;
		logic       nend;
		err_t       err;
		logic       done;
	} token_res_t;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_BYTES = 1050;
	localparam int IDLE_PCT     = 24;
	localparam int HOLD_AT      = 300;
	localparam int HOLD_LEN     = 80;
	localparam int CALM_FROM    = 600;
	localparam int CALM_TO      = 760;
	localparam int SETTLE       = 8;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_LO_A  = 8'h61;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] ch = '0;
	logic       last_byte = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [3:0] token_kind;
	logic [7:0] data_byte;
	logic       number_end;
	logic [3:0] error_code;
	logic       doc_done;

	doc_byte_t  byte_q[$];
	token_res_t token_q[$];
	logic [7:0] doc_text[$];
	int         sent_cnt = 0;
	int         fails = 0;
	int         cycles = 0;
	int         hold_left = 0;
	logic       hold_done = 1'b0;
	logic       calm;

	// parser model state
	phase_t     ps_phase = PH_OPEN;
	logic       ps_pair = 1'b0;
	logic [2:0] ps_skip = '0;
	nphase_t    ps_num = NP_EXP_DIG;
	err_t       ps_err = ER_NONE;

	json_flat_object_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.ch(ch),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.token_kind(token_kind),
		.data_byte(data_byte),
		.number_end(number_end),
		.error_code(error_code),
		.doc_done(doc_done)
	);

	always #10 clk = ~clk;

	assign calm = (sent_cnt >= CALM_FROM) && (sent_cnt < CALM_TO);

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_ZERO + 8'd9);
	endfunction

	function automatic nres_t number_step(input logic [7:0] c);
		logic d, e;
		d = is_digit(c);
		e = (c == CH_LO_E) || (c == CH_UP_E);
		case (ps_num)
		NP_SIGN: begin
			if (c == CH_ZERO) ps_num = NP_ZERO;
			else if (d) ps_num = NP_INT;
			else return NR_BAD;
		end
		NP_ZERO: begin
			// a digit after a leading zero closes the number
			if (c == CH_POINT) ps_num = NP_POINT;
			else if (e) ps_num = NP_E;
			else return NR_END;
		end
		NP_INT: begin
			if (!d) begin
				if (c == CH_POINT) ps_num = NP_POINT;
				else if (e) ps_num = NP_E;
				else return NR_END;
			end
		end
		NP_POINT: begin
			if (d) ps_num = NP_FRAC;
			else return NR_BAD;
		end
		NP_FRAC: begin
			if (!d) begin
				if (e) ps_num = NP_E;
				else return NR_END;
			end
		end
		NP_E: begin
			if (c == CH_PLUS || c == CH_MINUS) ps_num = NP_EXP_SIGN;
			else if (d) ps_num = NP_EXP_DIG;
			else return NR_BAD;
		end
		NP_EXP_SIGN: begin
			if (d) ps_num = NP_EXP_DIG;
			else return NR_BAD;
		end
		default: begin
			if (!d) return NR_END;
		end
		endcase
		return NR_TAKE;
	endfunction

	// body, escape and \u phases of a key or a string value
	function automatic err_t text_step(input logic [7:0] c, input logic is_key,
			inout tok_t kind, inout logic [7:0] data);
		phase_t body, esc, hex;
		tok_t   byte_tok;
		logic [7:0] v;
		if (is_key) begin
			body = PH_KEY; esc = PH_KEY_ESC; hex = PH_KEY_HEX; byte_tok = TK_KEY_BYTE;
		end else begin
			body = PH_STR; esc = PH_STR_ESC; hex = PH_STR_HEX; byte_tok = TK_STR_BYTE;
		end
		if (ps_phase == body) begin
			if (c == CH_QUOTE) begin
				if (is_key) begin
					kind = TK_KEY_END;
					ps_phase = PH_COLON;
				end else begin
					kind = TK_STR_END;
					ps_phase = PH_MEMBER;
					ps_pair = 1'b1;
				end
			end else if (c == CH_BSLASH) begin
				ps_phase = esc;
			end else if (c == CH_NUL) begin
				return ER_UNTERM;
			end else begin
				kind = byte_tok;
				data = c;
			end
			return ER_NONE;
		end
		if (ps_phase == esc) begin
			case (c)
			CH_QUOTE, CH_BSLASH, CH_SLASH: v = c;
			CH_LO_B: v = CH_BS;
			CH_LO_F: v = CH_FF;
			CH_LO_N: v = CH_LF;
			CH_LO_R: v = CH_CR;
			CH_LO_T: v = CH_TAB;
			CH_LO_U: begin
				ps_skip = HEX_SKIP;
				ps_phase = hex;
				return ER_NONE;
			end
			default: return ER_ESCAPE;
			endcase
			kind = byte_tok;
			data = v;
			ps_phase = body;
			return ER_NONE;
		end
		if (ps_skip != 0) ps_skip--;
		if (ps_skip == 0) ps_phase = body;
		return ER_NONE;
	endfunction

	function automatic err_t parse_core(input logic [7:0] c, inout tok_t kind,
			inout logic [7:0] data, inout logic nend);
		nres_t r;
		if (ps_phase == PH_NUMBER) begin
			r = number_step(c);
			if (r == NR_TAKE) begin
				kind = TK_NUM_BYTE;
				data = c;
				return ER_NONE;
			end
			if (r == NR_BAD) return ER_NUMBER;
			// number closed by this byte: handle the byte as a member separator
			nend = 1'b1;
			ps_phase = PH_MEMBER;
			ps_pair = 1'b1;
		end
		case (ps_phase)
		PH_OPEN: begin
			if (is_space(c)) return ER_NONE;
			if (c != CH_LBRACE) return ER_OBJECT;
			kind = TK_OPEN;
			ps_phase = PH_MEMBER;
		end
		PH_MEMBER: begin
			if (is_space(c)) return ER_NONE;
			if (c == CH_RBRACE) begin
				kind = TK_CLOSE;
				ps_phase = PH_DONE;
			end else if (ps_pair) begin
				if (c != CH_COMMA) return ER_SEP;
				ps_phase = PH_KEYSTART;
			end else begin
				if (c != CH_QUOTE) return ER_STRSTART;
				ps_phase = PH_KEY;
			end
		end
		PH_KEYSTART: begin
			if (is_space(c)) return ER_NONE;
			if (c != CH_QUOTE) return ER_STRSTART;
			ps_phase = PH_KEY;
		end
		PH_KEY, PH_KEY_ESC, PH_KEY_HEX: return text_step(c, 1'b1, kind, data);
		PH_STR, PH_STR_ESC, PH_STR_HEX: return text_step(c, 1'b0, kind, data);
		PH_COLON: begin
			if (is_space(c)) return ER_NONE;
			if (c != CH_COLON) return ER_SEP;
			ps_phase = PH_VALUE;
		end
		PH_VALUE: begin
			if (is_space(c)) return ER_NONE;
			if (c == CH_QUOTE) begin
				kind = TK_VAL_START;
				ps_phase = PH_STR;
			end else if (c == CH_MINUS || is_digit(c)) begin
				if (c == CH_MINUS) ps_num = NP_SIGN;
				else if (c == CH_ZERO) ps_num = NP_ZERO;
				else ps_num = NP_INT;
				kind = TK_NUM_BYTE;
				data = c;
				ps_phase = PH_NUMBER;
			end else if (c == CH_POINT || c == CH_LO_E || c == CH_UP_E) begin
				return ER_NUMBER;
			end else if (c == CH_LO_T) begin
				kind = TK_TRUE;
				ps_skip = TRUE_SKIP;
				ps_phase = PH_BOOL;
			end else if (c == CH_LO_F) begin
				kind = TK_FALSE;
				ps_skip = FALSE_SKIP;
				ps_phase = PH_BOOL;
			end else begin
				return ER_VALUE;
			end
		end
		PH_BOOL: begin
			if (ps_skip != 0) ps_skip--;
			if (ps_skip == 0) begin
				ps_phase = PH_MEMBER;
				ps_pair = 1'b1;
			end
		end
		PH_DONE: begin
			if (!is_space(c)) return ER_TRAILING;
		end
		default: return ER_OBJECT;
		endcase
		return ER_NONE;
	endfunction

	function automatic token_res_t predict_token(input logic [7:0] c, input logic last);
		token_res_t r;
		tok_t       k;
		logic [7:0] d;
		logic       n;
		err_t       e;
		k = TK_NONE;
		d = '0;
		n = 1'b0;
		r.done = 1'b0;
		if (ps_err != ER_NONE) begin
			e = ps_err;
		end else begin
			e = parse_core(c, k, d, n);
			if (e != ER_NONE) begin
				ps_err = e;
				k = TK_NONE;
				d = '0;
			end
		end
		if (last) begin
			if (e == ER_NONE && ps_phase != PH_DONE) e = ER_EARLY;
			r.done = (e == ER_NONE);
			ps_phase = PH_OPEN;
			ps_pair = 1'b0;
			ps_skip = '0;
			ps_num = NP_EXP_DIG;
			ps_err = ER_NONE;
		end
		r.kind = k;
		r.data = d;
		r.nend = n;
		r.err = e;
		return r;
	endfunction

	task automatic check_field(input string what, input int want, input int got);
		if (want != got) begin
			if (fails < 100)
				$display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
			fails++;
		end
	endtask

	task automatic push_one(input logic [7:0] c, input logic last);
		doc_byte_t b;
		b.ch = c;
		b.last = last;
		b.drain = 1'b0;
		byte_q.push_back(b);
	endtask

	task automatic push_str(input string s, input logic last_at_end);
		for (int i = 0; i < s.len(); i++)
			push_one(s[i], last_at_end && (i == s.len() - 1));
	endtask

	task automatic put_ws();
		logic [7:0] ws_set[6] = '{CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
		if ($urandom_range(2) == 0)
			repeat ($urandom_range(1, 2)) doc_text.push_back(ws_set[$urandom_range(5)]);
	endtask

	task automatic put_digit();
		doc_text.push_back(CH_ZERO + 8'($urandom_range(9)));
	endtask

	// text body up to and including the closing quote
	task automatic put_text();
		logic [7:0] esc_set[8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_LO_B,
			CH_LO_F, CH_LO_N, CH_LO_R, CH_LO_T};
		int r;
		logic [7:0] c;
		repeat ($urandom_range(0, 4)) begin
			r = $urandom_range(99);
			if (r < 55) begin
				doc_text.push_back(CH_LO_A + 8'($urandom_range(25)));
			end else if (r < 75) begin
				c = 8'($urandom_range(1, 255));
				if (c == CH_QUOTE || c == CH_BSLASH) c = CH_SPACE;
				doc_text.push_back(c);
			end else if (r < 88) begin
				doc_text.push_back(CH_BSLASH);
				doc_text.push_back(esc_set[$urandom_range(7)]);
			end else if (r < 95) begin
				doc_text.push_back(CH_BSLASH);
				doc_text.push_back(CH_LO_U);
				repeat (4) doc_text.push_back(8'($urandom_range(255)));
			end else if (r < 98) begin
				doc_text.push_back(CH_BSLASH);
				doc_text.push_back(8'($urandom_range(255)));
			end else begin
				doc_text.push_back(CH_NUL);
			end
		end
		doc_text.push_back(CH_QUOTE);
	endtask

	task automatic put_number();
		int r;
		if ($urandom_range(2) == 0) doc_text.push_back(CH_MINUS);
		if ($urandom_range(3) == 0) begin
			doc_text.push_back(CH_ZERO);
		end else begin
			doc_text.push_back(CH_ZERO + 8'($urandom_range(1, 9)));
			repeat ($urandom_range(0, 3)) put_digit();
		end
		if ($urandom_range(2) == 0) begin
			doc_text.push_back(CH_POINT);
			repeat ($urandom_range(1, 3)) put_digit();
		end
		if ($urandom_range(2) == 0) begin
			doc_text.push_back($urandom_range(1) ? CH_LO_E : CH_UP_E);
			r = $urandom_range(2);
			if (r == 1) doc_text.push_back(CH_PLUS);
			else if (r == 2) doc_text.push_back(CH_MINUS);
			repeat ($urandom_range(1, 2)) put_digit();
		end
	endtask

	task automatic put_bool(input logic truth);
		string rest;
		rest = truth ? "rue" : "alse";
		doc_text.push_back(truth ? CH_LO_T : CH_LO_F);
		// letters are not checked, so scramble some
		for (int i = 0; i < rest.len(); i++)
			doc_text.push_back(($urandom_range(4) == 0) ? 8'($urandom_range(255)) : rest[i]);
	endtask

	task automatic make_doc(input logic drain);
		int n, r, k;
		doc_byte_t b;
		doc_text.delete();
		if ($urandom_range(99) < 8) begin
			repeat ($urandom_range(1, 6)) doc_text.push_back(8'($urandom_range(255)));
		end else begin
			put_ws();
			doc_text.push_back(CH_LBRACE);
			n = $urandom_range(0, 3);
			for (int i = 0; i < n; i++) begin
				put_ws();
				if (i > 0) begin
					doc_text.push_back(CH_COMMA);
					put_ws();
				end
				doc_text.push_back(CH_QUOTE);
				put_text();
				put_ws();
				doc_text.push_back(CH_COLON);
				put_ws();
				r = $urandom_range(19);
				if (r == 0) begin
					doc_text.push_back(8'($urandom_range(255)));
				end else if (r < 8) begin
					doc_text.push_back(CH_QUOTE);
					put_text();
				end else if (r < 15) begin
					put_number();
				end else begin
					put_bool(r < 17);
				end
			end
			put_ws();
			doc_text.push_back(CH_RBRACE);
			put_ws();
			// break a share of the documents
			r = $urandom_range(99);
			k = $urandom_range(doc_text.size() - 1);
			if (r < 68) begin
			end else if (r < 78) begin
				doc_text[k] = 8'($urandom_range(255));
			end else if (r < 86) begin
				doc_text = doc_text[0:k];
			end else if (r < 93) begin
				doc_text.insert(k, 8'($urandom_range(255)));
			end else begin
				repeat ($urandom_range(1, 2)) doc_text.push_back(8'($urandom_range(255)));
			end
		end
		for (int i = 0; i < doc_text.size(); i++) begin
			b.ch = doc_text[i];
			b.last = (i == doc_text.size() - 1);
			b.drain = drain && (i == 0);
			byte_q.push_back(b);
		end
	endtask

	// byte driver
	always @(posedge clk or negedge arst_n) begin : drive_proc
		doc_byte_t b;
		logic go;
		if (!arst_n) begin
			in_valid <= 1'b0;
			ch <= '0;
			last_byte <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				token_q.push_back(predict_token(ch, last_byte));
				sent_cnt++;
			end
			if (!in_valid || in_ready) begin
				go = 1'b0;
				// a drain mark holds the byte until every result is back
				if (byte_q.size() != 0 && (!byte_q[0].drain || token_q.size() == 0))
					go = calm || ($urandom_range(99) >= IDLE_PCT);
				if (go) begin
					b = byte_q.pop_front();
					in_valid <= 1'b1;
					ch <= b.ch;
					last_byte <= b.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// long output stall once the stream is well under way
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && sent_cnt >= HOLD_AT) begin
			hold_left <= HOLD_LEN;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin : watch_proc
		token_res_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (token_q.size() == 0) begin
					if (fails < 100)
						$display("%0t: unexpected result: expected none, actual kind %0d err %0d",
							$time, token_kind, error_code);
					fails++;
				end else begin
					want = token_q.pop_front();
					check_field("token_kind", want.kind, token_kind);
					check_field("data_byte", want.data, data_byte);
					check_field("number_end", want.nend, number_end);
					check_field("error_code", want.err, error_code);
					check_field("doc_done", want.done, doc_done);
				end
			end
			out_ready <= (hold_left == 0) && (calm || ($urandom_range(99) >= IDLE_PCT));
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("** json_flat_object_parser: FAILED **");
			$finish;
		end
	end

	initial begin
		int first;
		// leading zero then digit, byte extremes, NUL in key, NUL after backslash,
		// point opening a value, junk after the closing brace
		push_str("{\"\":01}", 1'b1);
		push_one(8'hFF, 1'b1);
		push_one(CH_NUL, 1'b1);
		push_str("{\"", 1'b0);
		push_one(CH_NUL, 1'b1);
		push_str("{\"\\", 1'b0);
		push_one(CH_NUL, 1'b1);
		push_str("{\"\":.", 1'b1);
		push_str("{}x", 1'b1);
		first = 1;
		while (byte_q.size() < RANDOM_BYTES + 25) begin
			make_doc(first == 1 || $urandom_range(29) == 0);
			first = 0;
		end

		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (byte_q.size() != 0 || in_valid || token_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (fails == 0)
			$display("** json_flat_object_parser: PASSED **");
		else
			$display("** json_flat_object_parser: FAILED **");
		$finish;
	end

endmodule
